// ----- hdl/sfgd_pkg.sv -----
// Package for the shake and flip gesture detector.
// Holds the word types, result codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package sfgd_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd2;

    localparam logic [15:0] FLIP_LIMIT_RST = 16'd200;
    localparam logic [15:0] MOVE_LIMIT_RST = 16'd100;
    localparam logic [15:0] WINDOW_SECONDS_RST = 16'd20;

    localparam logic [1:0] MV_NONE = 2'd0;
    localparam logic [1:0] MV_FLIP = 2'd1;
    localparam logic [1:0] MV_UPDOWN = 2'd2;
    localparam logic [1:0] MV_LEFTRIGHT = 2'd3;

    localparam logic [1:0] GS_NONE = 2'd0;
    localparam logic [1:0] GS_FLIP = 2'd1;
    localparam logic [1:0] GS_SHAKE_UPDOWN = 2'd2;
    localparam logic [1:0] GS_SHAKE_LEFTRIGHT = 2'd3;

    localparam logic DIR_UPDOWN = 1'b0;
    localparam logic DIR_LEFTRIGHT = 1'b1;

    typedef struct packed {
        logic signed [15:0] prev_x;
        logic signed [15:0] prev_z;
        logic signed [15:0] curr_x;
        logic signed [15:0] curr_z;
        logic [31:0]        now_seconds;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  movement;
        logic [1:0]  gesture;
        logic [15:0] updown_count;
        logic [15:0] leftright_count;
    } t_out_word;

    typedef struct packed {
        logic       flip;
        logic       moved;
        logic       dir;
        logic [1:0] movement;
    } t_class;

    typedef struct packed {
        logic        valid;
        logic        dir;
        logic [31:0] time_s;
    } t_cell_state;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ----- hdl/sfgd_classify.sv -----
// Sample pair classifier of the gesture detector.
// Decides flip, up-down or left-right movement from one input word.
// Depends on sfgd_pkg.
`timescale 1ns / 1ps

module sfgd_classify (
    input  sfgd_pkg::t_in_word i_word,
    input  logic [15:0]        i_flip_limit,
    input  logic [15:0]        i_move_limit,
    output sfgd_pkg::t_class   o_class
);

    logic signed [17:0] w_zsum;
    logic signed [17:0] w_zrise;
    logic signed [17:0] w_xrise;
    logic signed [17:0] w_lim;
    logic [17:0]        w_zsum_abs;
    logic [17:0]        w_zdist;
    logic [17:0]        w_xdist;
    logic               w_flip;
    logic               w_ud;
    logic               w_lr;

    assign w_zsum = $signed({{2{i_word.prev_z[15]}}, i_word.prev_z})
                  + $signed({{2{i_word.curr_z[15]}}, i_word.curr_z});
    assign w_zrise = $signed({{2{i_word.curr_z[15]}}, i_word.curr_z})
                   - $signed({{2{i_word.prev_z[15]}}, i_word.prev_z});
    assign w_xrise = $signed({{2{i_word.curr_x[15]}}, i_word.curr_x})
                   - $signed({{2{i_word.prev_x[15]}}, i_word.prev_x});
    assign w_lim = $signed({2'b00, i_move_limit});

    assign w_zsum_abs = w_zsum[17] ? 18'(-w_zsum) : 18'(w_zsum);
    assign w_zdist = w_zrise[17] ? 18'(-w_zrise) : 18'(w_zrise);
    assign w_xdist = w_xrise[17] ? 18'(-w_xrise) : 18'(w_xrise);

    assign w_flip = (w_zsum_abs <= {2'b00, i_flip_limit});
    assign w_ud = !w_flip && (w_zrise > w_lim) && (w_zdist > w_xdist);
    assign w_lr = !w_flip && !w_ud && (w_xrise > w_lim) && (w_xdist > w_zdist);

    always_comb begin
        o_class.flip = w_flip;
        o_class.moved = w_ud || w_lr;
        o_class.dir = w_lr ? sfgd_pkg::DIR_LEFTRIGHT : sfgd_pkg::DIR_UPDOWN;
        if (w_flip) begin
            o_class.movement = sfgd_pkg::MV_FLIP;
        end else if (w_ud) begin
            o_class.movement = sfgd_pkg::MV_UPDOWN;
        end else if (w_lr) begin
            o_class.movement = sfgd_pkg::MV_LEFTRIGHT;
        end else begin
            o_class.movement = sfgd_pkg::MV_NONE;
        end
    end

endmodule

// ----- hdl/sfgd_cell.sv -----
// One entry of the movement history chain.
// Holds direction, time and valid bit, shifts from its neighbor and extends the match chain.
// Depends on sfgd_pkg.
`timescale 1ns / 1ps

module sfgd_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfgd_pkg::t_cell_ctl   i_ctl,
    input  sfgd_pkg::t_cell_state i_prev,
    input  logic                  i_dir,
    input  logic                  i_match,
    output sfgd_pkg::t_cell_state o_state,
    output logic                  o_match
);

    logic        r_valid;
    logic        r_dir;
    logic [31:0] r_time;
    logic        n_valid;
    logic        n_dir;
    logic [31:0] n_time;

    always_comb begin
        n_valid = r_valid;
        n_dir = r_dir;
        n_time = r_time;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
            n_dir = 1'b0;
            n_time = '0;
        end else if (i_ctl.shift) begin
            n_valid = i_prev.valid;
            n_dir = i_prev.dir;
            n_time = i_prev.time_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_dir <= n_dir;
        r_time <= n_time;
    end

    assign o_state = '{valid: r_valid, dir: r_dir, time_s: r_time};
    assign o_match = i_match && (r_dir == i_dir);

endmodule

// ----- hdl/shake_flip_gesture_detector.sv -----
// Shake and flip gesture detector, top level.
// Uses sfgd_pkg, sfgd_classify and a chain of sfgd_cell history entries.
//
// The input channel (i_valid, o_stall, i_data) takes one word of two
// accelerometer samples and a time stamp per cycle while o_stall is low.
// The output channel (o_valid, i_stall, o_data) returns exactly one result
// word for each input word, in order: the movement of the sample pair, any
// gesture, and both movement counts after this word.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the flip
// limit, move limit and window registers; writes to an unused index are
// ignored. Write it only while no word is in flight.
// A word accepted on the input is classified into the first stage; as it
// leaves that stage, the history chain is updated and the result is loaded
// into the output register. Throughput is one word per cycle while the
// receiver does not stall, as the history chain updates in the cycle a word
// leaves the first stage, and the gesture check is a short compare chain.
// While the receiver stalls, the output register holds its word, the first
// stage still fills, and o_stall rises only once both stages are full.
// Synchronous reset empties both stages and the history and loads the
// register reset values; the counters return to zero.
`timescale 1ns / 1ps

module shake_flip_gesture_detector #(
    parameter int unsigned HISTORY_DEPTH = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  sfgd_pkg::t_in_word                    i_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output sfgd_pkg::t_out_word                   o_data,
    input  logic                                  i_cfg_we,
    input  logic [sfgd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sfgd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [15:0] r_flip_limit;
    logic [15:0] r_move_limit;
    logic [15:0] r_window;

    logic                 r_s1_valid;
    sfgd_pkg::t_class     r_s1_cls;
    logic [31:0]          r_s1_time;
    logic                 r_out_valid;
    sfgd_pkg::t_out_word  r_out;
    sfgd_pkg::t_out_word  n_out;
    logic [15:0]          r_ud_cnt;
    logic [15:0]          r_lr_cnt;
    logic [15:0]          n_ud_cnt;
    logic [15:0]          n_lr_cnt;

    sfgd_pkg::t_class      w_cls;
    sfgd_pkg::t_cell_ctl   w_ctl;
    sfgd_pkg::t_cell_state w_new;
    sfgd_pkg::t_cell_state w_state [HISTORY_DEPTH];
    logic                  w_match [HISTORY_DEPTH];
    logic                  w_out_ready;
    logic                  w_s1_ready;
    logic                  w_s1_adv;
    logic                  w_in_acc;
    logic [31:0]           w_span;
    logic                  w_gesture;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_s1_adv = r_s1_valid && w_out_ready;
    assign w_s1_ready = !r_s1_valid || w_out_ready;
    assign w_in_acc = i_valid && w_s1_ready;
    assign o_stall = !w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_limit <= sfgd_pkg::FLIP_LIMIT_RST;
            r_move_limit <= sfgd_pkg::MOVE_LIMIT_RST;
            r_window <= sfgd_pkg::WINDOW_SECONDS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfgd_pkg::REG_FLIP_LIMIT: begin
                    r_flip_limit <= i_cfg_data;
                end
                sfgd_pkg::REG_MOVE_LIMIT: begin
                    r_move_limit <= i_cfg_data;
                end
                sfgd_pkg::REG_WINDOW_SECONDS: begin
                    r_window <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    sfgd_classify u_classify (
        .i_word       (i_data),
        .i_flip_limit (r_flip_limit),
        .i_move_limit (r_move_limit),
        .o_class      (w_cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
        if (w_in_acc) begin
            r_s1_cls <= w_cls;
            r_s1_time <= i_data.now_seconds;
        end
    end

    assign w_new = '{valid: 1'b1, dir: r_s1_cls.dir, time_s: r_s1_time};

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        sfgd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  ((g == 0) ? w_new : w_state[(g == 0) ? 0 : g - 1]),
            .i_dir   (r_s1_cls.dir),
            .i_match ((g == 0) ? 1'b1 : w_match[(g == 0) ? 0 : g - 1]),
            .o_state (w_state[g]),
            .o_match (w_match[g])
        );
    end

    assign w_span = r_s1_time - w_state[HISTORY_DEPTH-2].time_s;
    assign w_gesture = r_s1_cls.moved && w_state[HISTORY_DEPTH-2].valid
                     && w_match[HISTORY_DEPTH-2] && (w_span <= {16'd0, r_window});

    assign w_ctl.clear = w_s1_adv && (r_s1_cls.flip || w_gesture);
    assign w_ctl.shift = w_s1_adv && r_s1_cls.moved && !w_gesture;

    always_comb begin
        n_ud_cnt = r_ud_cnt;
        n_lr_cnt = r_lr_cnt;
        if (r_s1_cls.movement == sfgd_pkg::MV_UPDOWN) begin
            n_ud_cnt = r_ud_cnt + 16'd1;
        end
        if (r_s1_cls.movement == sfgd_pkg::MV_LEFTRIGHT) begin
            n_lr_cnt = r_lr_cnt + 16'd1;
        end
        n_out.movement = r_s1_cls.movement;
        n_out.updown_count = n_ud_cnt;
        n_out.leftright_count = n_lr_cnt;
        if (r_s1_cls.flip) begin
            n_out.gesture = sfgd_pkg::GS_FLIP;
        end else if (w_gesture) begin
            n_out.gesture = (r_s1_cls.dir == sfgd_pkg::DIR_LEFTRIGHT)
                          ? sfgd_pkg::GS_SHAKE_LEFTRIGHT : sfgd_pkg::GS_SHAKE_UPDOWN;
        end else begin
            n_out.gesture = sfgd_pkg::GS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ud_cnt <= '0;
            r_lr_cnt <= '0;
        end else begin
            if (w_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s1_adv) begin
                r_ud_cnt <= n_ud_cnt;
                r_lr_cnt <= n_lr_cnt;
            end
        end
        if (w_s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data = r_out;

endmodule

// ----- hdl/sfgd_checker.sv -----
// Port-level checker for the shake and flip gesture detector.
// Watches the output channel over time; bound to the top level below.
// Depends on sfgd_pkg and shake_flip_gesture_detector.
`timescale 1ns / 1ps

module sfgd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input sfgd_pkg::t_out_word o_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word present right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_flip_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.movement == sfgd_pkg::MV_FLIP)
            |-> (o_data.gesture == sfgd_pkg::GS_FLIP))
        else $error("flip movement without flip gesture");

    a_shake_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_data.gesture == sfgd_pkg::GS_SHAKE_UPDOWN
                  && o_data.movement != sfgd_pkg::MV_UPDOWN)
                 || (o_data.gesture == sfgd_pkg::GS_SHAKE_LEFTRIGHT
                  && o_data.movement != sfgd_pkg::MV_LEFTRIGHT)) |-> 1'b0)
        else $error("shake gesture does not match its movement");

    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.movement == sfgd_pkg::MV_NONE)
            |-> (o_data.gesture == sfgd_pkg::GS_NONE))
        else $error("gesture reported without a movement");

endmodule

bind shake_flip_gesture_detector sfgd_checker u_sfgd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ----- bench/shake_flip_gesture_detector_tb.sv -----
// Self-checking testbench for the shake and flip gesture detector.
// Depends on sfgd_pkg and shake_flip_gesture_detector; runs directed and random
// words through a predictor of the history and counters with random idling.
`timescale 1ns / 1ps

module shake_flip_gesture_detector_tb;

    localparam int DEPTH = 3;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [sfgd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    sfgd_pkg::t_in_word             i_data = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    sfgd_pkg::t_out_word            o_data;
    logic                           i_cfg_we = 1'b0;
    logic [sfgd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sfgd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: entry 0 of the history is the newest.
    logic        hist_dir [DEPTH];
    logic [31:0] hist_time [DEPTH];
    logic        hist_valid [DEPTH];
    logic [15:0] ud_count;
    logic [15:0] lr_count;
    logic [15:0] flip_lim;
    logic [15:0] move_lim;
    logic [15:0] window_s;

    sfgd_pkg::t_out_word pending_results[$];
    sfgd_pkg::t_out_word want;
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [31:0] sample_time = 32'd0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_span = 0;
    int          stall_tick = 0;

    shake_flip_gesture_detector #(
        .HISTORY_DEPTH(DEPTH)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic sfgd_pkg::t_in_word pack_sample(input int px, input int pz, input int cx,
                                                       input int cz, input logic [31:0] t);
        sfgd_pkg::t_in_word w;
        w.prev_x = 16'(px);
        w.prev_z = 16'(pz);
        w.curr_x = 16'(cx);
        w.curr_z = 16'(cz);
        w.now_seconds = t;
        return w;
    endfunction

    function automatic logic [1:0] classify_motion(input sfgd_pkg::t_in_word w);
        int z_sum;
        int z_rise;
        int x_rise;
        int z_dist;
        int x_dist;
        z_sum = int'($signed(w.prev_z)) + int'($signed(w.curr_z));
        z_rise = int'($signed(w.curr_z)) - int'($signed(w.prev_z));
        x_rise = int'($signed(w.curr_x)) - int'($signed(w.prev_x));
        z_dist = (z_rise < 0) ? -z_rise : z_rise;
        x_dist = (x_rise < 0) ? -x_rise : x_rise;
        if (z_sum < 0) z_sum = -z_sum;
        if (z_sum <= int'(flip_lim)) return sfgd_pkg::MV_FLIP;
        if (z_rise > int'(move_lim) && z_dist > x_dist) return sfgd_pkg::MV_UPDOWN;
        if (x_rise > int'(move_lim) && x_dist > z_dist) return sfgd_pkg::MV_LEFTRIGHT;
        return sfgd_pkg::MV_NONE;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < DEPTH; i++) begin
            hist_dir[i] = 1'b0;
            hist_time[i] = 32'd0;
            hist_valid[i] = 1'b0;
        end
    endfunction

    function automatic void predict_gesture(input sfgd_pkg::t_in_word w);
        sfgd_pkg::t_out_word r;
        logic [1:0]  mv;
        logic        dir;
        logic        same;
        logic [31:0] span;
        mv = classify_motion(w);
        r = '0;
        r.movement = mv;
        r.gesture = sfgd_pkg::GS_NONE;
        if (mv == sfgd_pkg::MV_FLIP) begin
            r.gesture = sfgd_pkg::GS_FLIP;
            clear_history();
        end else if (mv != sfgd_pkg::MV_NONE) begin
            dir = (mv == sfgd_pkg::MV_LEFTRIGHT) ? sfgd_pkg::DIR_LEFTRIGHT
                                                 : sfgd_pkg::DIR_UPDOWN;
            if (dir == sfgd_pkg::DIR_LEFTRIGHT) lr_count = lr_count + 16'd1;
            else ud_count = ud_count + 16'd1;
            for (int i = DEPTH - 1; i > 0; i--) begin
                hist_dir[i] = hist_dir[i-1];
                hist_time[i] = hist_time[i-1];
                hist_valid[i] = hist_valid[i-1];
            end
            hist_dir[0] = dir;
            hist_time[0] = w.now_seconds;
            hist_valid[0] = 1'b1;
            if (hist_valid[DEPTH-1]) begin
                same = 1'b1;
                for (int i = 1; i < DEPTH; i++) begin
                    if (hist_dir[i] != dir) same = 1'b0;
                end
                span = hist_time[0] - hist_time[DEPTH-1];
                if (same && span <= {16'd0, window_s}) begin
                    r.gesture = (dir == sfgd_pkg::DIR_LEFTRIGHT)
                              ? sfgd_pkg::GS_SHAKE_LEFTRIGHT : sfgd_pkg::GS_SHAKE_UPDOWN;
                    clear_history();
                end
            end
        end
        r.updown_count = ud_count;
        r.leftright_count = lr_count;
        pending_results.push_back(r);
    endfunction

    // Builds a word of the requested class under the current limits, retrying
    // random candidates; some settings make a class impossible.
    function automatic sfgd_pkg::t_in_word make_word(input logic [1:0] kind,
                                                     input logic [31:0] t);
        sfgd_pkg::t_in_word w;
        int rise;
        int off;
        int a;
        int b;
        int c;
        int s;
        int ml;
        w = '0;
        ml = int'(move_lim);
        for (int tries = 0; tries < 64; tries++) begin
            rise = ml + 1 + int'($urandom_range(0, 400));
            if (rise > 65535) rise = 65535;
            off = int'($urandom_range(0, rise - 1));
            if ($urandom_range(0, 1) == 1) off = -off;
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535 - rise)) - 32768;
            c = int'($urandom_range(0, 65535)) - 32768;
            case (kind)
                sfgd_pkg::MV_UPDOWN: begin
                    w = pack_sample(a, b, clamp16(a + off), b + rise, t);
                end
                sfgd_pkg::MV_LEFTRIGHT: begin
                    w = pack_sample(b, a, b + rise, clamp16(a + off), t);
                end
                sfgd_pkg::MV_FLIP: begin
                    s = int'($urandom_range(0, flip_lim));
                    if ($urandom_range(0, 1) == 1) s = -s;
                    b = clamp16(s / 2 + int'($urandom_range(0, 2000)) - 1000);
                    w = pack_sample(a, b, clamp16(a + off), clamp16(s - b), t);
                end
                default: begin
                    w = pack_sample(c, a,
                                    clamp16(c + int'($urandom_range(0, 2 * ml)) - ml),
                                    clamp16(a + int'($urandom_range(0, 2 * ml)) - ml), t);
                end
            endcase
            if (classify_motion(w) == kind) break;
        end
        return w;
    endfunction

    task automatic send_sample(input sfgd_pkg::t_in_word w);
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        predict_gesture(w);
        words_sent++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(1, 30);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sfgd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            sfgd_pkg::REG_FLIP_LIMIT: flip_lim = value;
            sfgd_pkg::REG_MOVE_LIMIT: move_lim = value;
            sfgd_pkg::REG_WINDOW_SECONDS: window_s = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [15:0] flip, input logic [15:0] move,
                              input logic [15:0] window);
        write_reg(sfgd_pkg::REG_FLIP_LIMIT, flip);
        write_reg(sfgd_pkg::REG_MOVE_LIMIT, move);
        write_reg(sfgd_pkg::REG_WINDOW_SECONDS, window);
    endtask

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
        fail_count++;
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
    endtask

    task automatic test_flip_and_extremes();
        send_sample(pack_sample(0, 0, 0, 0, 32'd1));
        send_sample(pack_sample(0, 100, 0, 100, 32'd1));
        send_sample(pack_sample(0, 100, 0, 101, 32'd1));
        send_sample(pack_sample(0, -100, 0, -101, 32'd1));
        send_sample(pack_sample(-32768, -32768, -32768, -32768, 32'd1));
        send_sample(pack_sample(-32768, 32767, 32767, 32767, 32'd2));
    endtask

    task automatic test_move_threshold();
        send_sample(pack_sample(0, 1000, 0, 1100, 32'd3));
        send_sample(pack_sample(0, 1000, 0, 1101, 32'd3));
        send_sample(pack_sample(0, 1000, 300, 1300, 32'd3));
        send_sample(pack_sample(0, 1300, 300, 1000, 32'd3));
    endtask

    task automatic test_shake_window();
        send_sample(pack_sample(0, 0, 0, 0, 32'd100));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd100));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd105));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd110));
        send_sample(pack_sample(0, 1000, 1000, 1000, 32'd200));
        send_sample(pack_sample(0, 1000, 1000, 1000, 32'd210));
        send_sample(pack_sample(0, 1000, 1000, 1000, 32'd221));
        send_sample(pack_sample(0, 1000, 1000, 1000, 32'd222));
    endtask

    task automatic test_flip_clears_history();
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd400));
        send_sample(pack_sample(0, 0, 0, 0, 32'd400));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd402));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd403));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd404));
    endtask

    task automatic test_time_wrap();
        send_sample(pack_sample(0, 1000, 0, 2000, 32'hFFFF_FFFE));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'hFFFF_FFFF));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd1));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd50));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd10));
        send_sample(pack_sample(0, 1000, 0, 2000, 32'd20));
    endtask

    task automatic test_register_extremes();
        set_limits(16'd0, 16'd0, 16'd0);
        send_sample(pack_sample(0, 0, 0, 0, 32'd7));
        send_sample(pack_sample(0, 0, 0, 1, 32'd7));
        send_sample(pack_sample(0, 0, 0, 1, 32'd7));
        send_sample(pack_sample(0, 0, 0, 1, 32'd7));
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(pack_sample(0, 0, 0, 1, 32'd8));
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(pack_sample(-32768, -32768, 32767, -32768, 32'd9));
        send_sample(pack_sample(32767, 32767, -32768, 32767, 32'd9));
    endtask

    // Mostly runs of same-direction movements with random content, plus
    // flips, quiet samples and raw random words.
    task automatic run_phase(input logic [15:0] flip, input logic [15:0] move,
                             input logic [15:0] window, input int n_items);
        int unsigned        start;
        int                 len;
        int                 pick;
        logic               lr;
        sfgd_pkg::t_in_word raw;
        set_limits(flip, move, window);
        start = words_sent;
        while (words_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                lr = 1'($urandom_range(0, 1));
                len = $urandom_range(2, 4);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0: sample_time = $urandom();
                        1: sample_time = 32'hFFFF_FFFF - $urandom_range(0, 20);
                        2: sample_time = sample_time + window_s + $urandom_range(1, 10);
                        3: sample_time = sample_time - $urandom_range(1, 5);
                        default: sample_time = sample_time
                                               + $urandom_range(0, int'(window_s) / 2 + 2);
                    endcase
                    if ($urandom_range(0, 7) == 0)
                        send_sample(make_word(sfgd_pkg::MV_NONE, sample_time));
                    send_sample(make_word(lr ? sfgd_pkg::MV_LEFTRIGHT : sfgd_pkg::MV_UPDOWN,
                                          sample_time));
                    if ($urandom_range(0, 15) == 0) lr = ~lr;
                end
            end else if (pick < 70) begin
                send_sample(make_word(sfgd_pkg::MV_FLIP, sample_time));
            end else if (pick < 85) begin
                send_sample(make_word(sfgd_pkg::MV_NONE, sample_time));
            end else begin
                raw = {$urandom(), $urandom(), $urandom()};
                send_sample(raw);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase(sfgd_pkg::FLIP_LIMIT_RST, sfgd_pkg::MOVE_LIMIT_RST,
                  sfgd_pkg::WINDOW_SECONDS_RST, 300);
        repeat (3) begin
            run_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 500)),
                      16'($urandom_range(0, 40)), 300);
        end
        run_phase(16'd0, 16'd0, 16'd0, 150);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 50);
        run_phase(16'd0, 16'hFFFF, 16'hFFFF, 100);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 100);
        run_phase(sfgd_pkg::FLIP_LIMIT_RST, sfgd_pkg::MOVE_LIMIT_RST,
                  sfgd_pkg::WINDOW_SECONDS_RST, 200);
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 256);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("result word arrived with no expected result pending");
            end else begin
                want = pending_results.pop_front();
                if (o_data.movement !== want.movement)
                    report_field("movement", want.movement, o_data.movement);
                if (o_data.gesture !== want.gesture)
                    report_field("gesture", want.gesture, o_data.gesture);
                if (o_data.updown_count !== want.updown_count)
                    report_field("updown_count", want.updown_count, o_data.updown_count);
                if (o_data.leftright_count !== want.leftright_count)
                    report_field("leftright_count", want.leftright_count,
                                 o_data.leftright_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("shake_flip_gesture_detector verification failed");
            $finish;
        end
    end

    initial begin
        flip_lim = sfgd_pkg::FLIP_LIMIT_RST;
        move_lim = sfgd_pkg::MOVE_LIMIT_RST;
        window_s = sfgd_pkg::WINDOW_SECONDS_RST;
        ud_count = 16'd0;
        lr_count = 16'd0;
        clear_history();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_flip_and_extremes();
        test_move_threshold();
        test_shake_window();
        test_flip_clears_history();
        test_time_wrap();
        test_register_extremes();
        test_random_traffic();
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("shake_flip_gesture_detector verification clean");
        end else begin
            $display("shake_flip_gesture_detector verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sfgd_pkg.sv
hdl/sfgd_classify.sv
hdl/sfgd_cell.sv
hdl/shake_flip_gesture_detector.sv
hdl/sfgd_checker.sv
bench/shake_flip_gesture_detector_tb.sv
